/* src/c8008_pkg.sv */
package c8008_pkg;
  localparam int unsigned STACK_DEPTH_DEF = 8;
  localparam int unsigned ADDR_BITS_DEF = 14;

  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_ADC = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_SBB = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_XOR = 3'd5;
  localparam logic [2:0] ALU_OR  = 3'd6;
  localparam logic [2:0] ALU_CMP = 3'd7;

  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;
  localparam logic [2:0] SRC_MEM = 3'd7;

  localparam logic [7:0] OP_HLT0 = 8'h00;
  localparam logic [7:0] OP_HLT1 = 8'h01;
  localparam logic [7:0] OP_HLT2 = 8'hFF;

  // zero, sign and parity with carry kept from c
  function automatic logic [3:0] zsp(input logic [7:0] v, input logic c);
    zsp = {~(^v), v[7], (v == 8'h00), c};
  endfunction
endpackage

/* src/cpu_8008_instruction_execute_unit.sv */
// 8008 instruction execute unit.
// Input channel (in_valid/in_ready) carries one instruction word: opcode, the two
// following bytes, the memory byte at H:L and the input port byte. The output
// channel (out_valid/out_ready) returns one result word per instruction: next PC,
// memory and port write requests, A, flags, halt and invalid-opcode marks.
// The instruction is decoded and executed by a single combinational pass from the
// architectural registers into the result register. Throughput is one instruction
// per cycle while results are taken; in_ready is high whenever the result
// register is empty or being taken in the same cycle, so back-to-back words flow
// without bubbles. When the receiver stalls, the result holds and input stalls.
// Reset (rst, synchronous) clears A..L, flags, the return stack, the stack
// pointer and the halt mark, and empties the result register. Once halted, the
// unit still answers each word with an unchanged state and no writes.
module cpu_8008_instruction_execute_unit
  import c8008_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opcode,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic [7:0]  hl_data,
  input  logic [7:0]  port_in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] next_pc,
  output logic        mem_write,
  output logic [13:0] mem_addr,
  output logic [7:0]  write_data,
  output logic        port_write,
  output logic [4:0]  port_number,
  output logic [7:0]  acc,
  output logic [3:0]  flags,
  output logic        halted,
  output logic        invalid_opcode
);
  localparam int unsigned SP_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SP_BITS-1:0] SP_LAST = SP_BITS'(STACK_DEPTH - 1);

  logic [7:0] regs [7];
  logic [7:0] regs_next [7];
  logic [3:0] flag_bits, flag_next;
  logic [ADDR_BITS-1:0] stack [STACK_DEPTH];
  logic [SP_BITS-1:0] sp, sp_next;
  logic halt_mark, halt_next;
  logic push, pop;
  logic [ADDR_BITS-1:0] ret_addr, pc, npc, target;
  logic [SP_BITS-1:0] sp_up, sp_dn;
  logic mw, pw, inv;
  logic [7:0] wd;
  logic [4:0] pn;
  logic [2:0] d, s;
  logic cond;
  logic accept;
  logic [7:0] src, alu_x, alu_r;
  logic [8:0] sum;
  logic alu_c;
  logic [2:0] alu_kind;
  logic do_alu;
  logic [7:0] incdec;
  logic [7:0] rot_a;
  logic rot_c;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  assign d  = opcode[5:3];
  assign s  = opcode[2:0];
  assign pc = stack[sp];
  assign target = ADDR_BITS'({third_byte[5:0], second_byte});
  assign cond = (flag_bits[opcode[4:3]] == opcode[5]);
  assign sp_up = (sp == SP_LAST) ? '0 : sp + 1'b1;
  assign sp_dn = (sp == '0) ? SP_LAST : sp - 1'b1;
  assign src = (s == SRC_MEM) ? hl_data : regs[s];
  assign alu_x = (opcode[7:6] == 2'b00) ? second_byte : src;
  assign alu_kind = d;
  assign incdec = opcode[0] ? regs[d] - 8'd1 : regs[d] + 8'd1;

  always_comb begin
    alu_c = 1'b0;
    sum = '0;
    unique case (alu_kind)
      ALU_ADD: sum = {1'b0, regs[REG_A]} + {1'b0, alu_x};
      ALU_ADC: sum = {1'b0, regs[REG_A]} + {1'b0, alu_x} + {8'd0, flag_bits[0]};
      ALU_SUB, ALU_CMP: sum = {1'b0, regs[REG_A]} - {1'b0, alu_x};
      ALU_SBB: sum = {1'b0, regs[REG_A]} - {1'b0, alu_x} - {8'd0, flag_bits[0]};
      ALU_AND: sum = {1'b0, regs[REG_A] & alu_x};
      ALU_XOR: sum = {1'b0, regs[REG_A] ^ alu_x};
      ALU_OR:  sum = {1'b0, regs[REG_A] | alu_x};
      default: sum = '0;
    endcase
    alu_r = sum[7:0];
    alu_c = sum[8];
  end

  // rotates: d[0] right, d[1] through carry
  always_comb begin
    rot_c = d[0] ? regs[REG_A][0] : regs[REG_A][7];
    if (d[0]) begin
      rot_a = {(d[1] ? flag_bits[0] : rot_c), regs[REG_A][7:1]};
    end else begin
      rot_a = {regs[REG_A][6:0], (d[1] ? flag_bits[0] : rot_c)};
    end
  end

  always_comb begin
    regs_next = regs;
    flag_next = flag_bits;
    halt_next = halt_mark;
    push = 1'b0;
    pop = 1'b0;
    ret_addr = '0;
    mw = 1'b0;
    pw = 1'b0;
    inv = 1'b0;
    wd = '0;
    pn = '0;
    do_alu = 1'b0;
    npc = pc + 1'b1;
    if (halt_mark) begin
      npc = pc;
    end else if (opcode == OP_HLT0 || opcode == OP_HLT1 || opcode == OP_HLT2) begin
      halt_next = 1'b1;
    end else begin
      unique case (opcode[7:6])
        2'b00: begin
          unique case (s)
            3'd0, 3'd1: begin
              if (d == 3'd7) begin
                inv = 1'b1;
              end else begin
                regs_next[d] = incdec;
                flag_next = zsp(incdec, flag_bits[0]);
              end
            end
            3'd2: begin
              if (d[2]) begin
                inv = 1'b1;
              end else begin
                regs_next[REG_A] = rot_a;
                flag_next = {flag_bits[3:1], rot_c};
              end
            end
            3'd3: pop = cond;
            3'd4: begin
              do_alu = 1'b1;
              npc = pc + ADDR_BITS'(2);
            end
            3'd5: begin
              push = 1'b1;
              ret_addr = pc + 1'b1;
              npc = ADDR_BITS'({d, 3'b000});
            end
            3'd6: begin
              if (d == SRC_MEM) begin
                mw = 1'b1;
                wd = second_byte;
              end else begin
                regs_next[d] = second_byte;
              end
              npc = pc + ADDR_BITS'(2);
            end
            default: pop = 1'b1;
          endcase
        end
        2'b01: begin
          if (opcode[0]) begin
            if (opcode[5:4] == 2'b00) begin
              pn = {2'b00, opcode[3:1]};
              regs_next[REG_A] = port_in_data;
            end else begin
              pn = opcode[5:1];
              pw = 1'b1;
              wd = regs[REG_A];
            end
          end else begin
            npc = pc + ADDR_BITS'(3);
            if (s[2] || cond) begin
              if (s[1]) begin
                push = 1'b1;
                ret_addr = pc + ADDR_BITS'(3);
              end
              npc = target;
            end
          end
        end
        2'b10: do_alu = 1'b1;
        default: begin
          if (d == SRC_MEM) begin
            mw = 1'b1;
            wd = src;
          end else begin
            regs_next[d] = src;
          end
        end
      endcase
      if (do_alu) begin
        if (alu_kind != ALU_CMP) regs_next[REG_A] = alu_r;
        flag_next = zsp(alu_r, (alu_kind[2] && alu_kind != ALU_CMP) ? 1'b0 : alu_c);
      end
    end
    sp_next = sp;
    if (push) sp_next = sp_up;
    else if (pop) begin
      sp_next = sp_dn;
      npc = stack[sp_dn];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) regs[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stack[i] <= '0;
      flag_bits <= '0;
      sp <= '0;
      halt_mark <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (accept) begin
        if (!halt_mark) begin
          regs <= regs_next;
          flag_bits <= flag_next;
          halt_mark <= halt_next;
          sp <= sp_next;
          if (push) stack[sp] <= ret_addr;
          stack[sp_next] <= npc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      next_pc <= 14'(npc);
      mem_write <= mw;
      mem_addr <= 14'({regs_next[REG_H][5:0], regs_next[REG_L]} & {ADDR_BITS{1'b1}});
      write_data <= wd;
      port_write <= pw;
      port_number <= pn;
      acc <= regs_next[REG_A];
      flags <= flag_next;
      halted <= halt_next;
      invalid_opcode <= inv;
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc))
    else $error("result dropped under stall");
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && halt_mark |=> !mem_write && !port_write && halted)
    else $error("write while halted");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_mark |=> halt_mark)
    else $error("halt mark cleared");
`endif
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import c8008_pkg::*;

  typedef struct packed {
    logic [13:0] next_pc;
    logic        mem_write;
    logic [13:0] mem_addr;
    logic [7:0]  write_data;
    logic        port_write;
    logic [4:0]  port_number;
    logic [7:0]  acc;
    logic [3:0]  flags;
    logic        halted;
    logic        invalid_opcode;
  } exec_result_t;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [7:0] BAD_OPS [6] = '{8'h22, 8'h2A, 8'h32, 8'h3A, 8'h38, 8'h39};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  opcode = '0;
  logic [7:0]  second_byte = '0;
  logic [7:0]  third_byte = '0;
  logic [7:0]  hl_data = '0;
  logic [7:0]  port_in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] next_pc;
  logic        mem_write;
  logic [13:0] mem_addr;
  logic [7:0]  write_data;
  logic        port_write;
  logic [4:0]  port_number;
  logic [7:0]  acc;
  logic [3:0]  flags;
  logic        halted;
  logic        invalid_opcode;

  // shadow copy of the architectural state
  logic [7:0]  gpr [7];
  logic [3:0]  cpu_flags;
  logic [13:0] ret_stack [STACK_DEPTH_DEF];
  logic [2:0]  stk_ptr;
  logic        halt_seen;

  exec_result_t pending_results [$];
  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  cpu_8008_instruction_execute_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .second_byte(second_byte), .third_byte(third_byte),
    .hl_data(hl_data), .port_in_data(port_in_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_pc(next_pc), .mem_write(mem_write), .mem_addr(mem_addr),
    .write_data(write_data), .port_write(port_write), .port_number(port_number),
    .acc(acc), .flags(flags), .halted(halted), .invalid_opcode(invalid_opcode)
  );

  always #10 clk = ~clk;

  function automatic void set_zsp(input logic [7:0] v);
    cpu_flags = {~(^v), v[7], (v == 8'h00), cpu_flags[0]};
  endfunction

  function automatic void run_alu(input logic [2:0] kind, input logic [7:0] x);
    logic [8:0] r;
    logic       cy;
    r = '0;
    cy = 1'b0;
    case (kind)
      ALU_ADD: begin r = {1'b0, gpr[REG_A]} + x; cy = r[8]; end
      ALU_ADC: begin r = {1'b0, gpr[REG_A]} + x + cpu_flags[0]; cy = r[8]; end
      ALU_SUB, ALU_CMP: begin r = {1'b0, gpr[REG_A]} - x; cy = r[8]; end
      ALU_SBB: begin r = {1'b0, gpr[REG_A]} - x - cpu_flags[0]; cy = r[8]; end
      ALU_AND: r = {1'b0, gpr[REG_A] & x};
      ALU_XOR: r = {1'b0, gpr[REG_A] ^ x};
      default: r = {1'b0, gpr[REG_A] | x};
    endcase
    if (kind != ALU_CMP) gpr[REG_A] = r[7:0];
    cpu_flags[0] = cy;
    set_zsp(r[7:0]);
  endfunction

  function automatic logic cond_met(input logic [7:0] op);
    return cpu_flags[op[4:3]] == op[5];
  endfunction

  function automatic exec_result_t execute(input logic [7:0] op, input logic [7:0] b2,
                                           input logic [7:0] b3, input logic [7:0] hl,
                                           input logic [7:0] pin);
    exec_result_t res;
    logic [13:0] pc, nxt, ret_addr, target;
    logic [2:0]  d, s, sp;
    logic [7:0]  src, a;
    logic        push, pop, nc;
    res = '0;
    sp = stk_ptr;
    pc = ret_stack[sp];
    nxt = pc;
    target = {b3[5:0], b2};
    d = op[5:3];
    s = op[2:0];
    src = (s == SRC_MEM) ? hl : gpr[s];
    push = 1'b0;
    pop = 1'b0;
    ret_addr = '0;
    if (!halt_seen) begin
      nxt = pc + 14'd1;
      if (op == OP_HLT0 || op == OP_HLT1 || op == OP_HLT2) begin
        halt_seen = 1'b1;
      end else if (op[7:6] == 2'd0) begin
        case (s)
          3'd0, 3'd1: begin
            if (d == 3'd7) begin
              res.invalid_opcode = 1'b1;
            end else begin
              gpr[d] = s[0] ? gpr[d] - 8'd1 : gpr[d] + 8'd1;
              set_zsp(gpr[d]);
            end
          end
          3'd2: begin
            if (d >= 3'd4) begin
              res.invalid_opcode = 1'b1;
            end else begin
              a = gpr[REG_A];
              nc = d[0] ? a[0] : a[7];
              if (d[0]) gpr[REG_A] = {d[1] ? cpu_flags[0] : nc, a[7:1]};
              else gpr[REG_A] = {a[6:0], d[1] ? cpu_flags[0] : nc};
              cpu_flags[0] = nc;
            end
          end
          3'd3: pop = cond_met(op);
          3'd4: begin run_alu(d, b2); nxt = pc + 14'd2; end
          3'd5: begin push = 1'b1; ret_addr = pc + 14'd1; nxt = {8'd0, d, 3'd0}; end
          3'd6: begin
            if (d == 3'd7) begin
              res.mem_write = 1'b1;
              res.write_data = b2;
            end else begin
              gpr[d] = b2;
            end
            nxt = pc + 14'd2;
          end
          default: pop = 1'b1;
        endcase
      end else if (op[7:6] == 2'd1) begin
        if (op[0]) begin
          if (op[5:4] == 2'd0) begin
            res.port_number = {2'd0, op[3:1]};
            gpr[REG_A] = pin;
          end else begin
            res.port_number = op[5:1];
            res.port_write = 1'b1;
            res.write_data = gpr[REG_A];
          end
        end else begin
          nxt = pc + 14'd3;
          if (s[2] || cond_met(op)) begin
            if (s[1]) begin push = 1'b1; ret_addr = pc + 14'd3; end
            nxt = target;
          end
        end
      end else if (op[7:6] == 2'd2) begin
        run_alu(d, src);
      end else begin
        if (d == 3'd7) begin
          res.mem_write = 1'b1;
          res.write_data = src;
        end else begin
          gpr[d] = src;
        end
      end
      if (push) begin
        ret_stack[sp] = ret_addr;
        sp = sp + 3'd1;
      end else if (pop) begin
        sp = sp - 3'd1;
        nxt = ret_stack[sp];
      end
      ret_stack[sp] = nxt;
      stk_ptr = sp;
    end
    res.next_pc = nxt;
    res.mem_addr = {gpr[REG_H][5:0], gpr[REG_L]};
    res.acc = gpr[REG_A];
    res.flags = cpu_flags;
    res.halted = halt_seen;
    return res;
  endfunction

  task automatic send_word(input logic [7:0] op, input logic [7:0] b2,
                           input logic [7:0] b3, input logic [7:0] hl,
                           input logic [7:0] pin);
    in_valid <= 1'b1;
    opcode <= op;
    second_byte <= b2;
    third_byte <= b3;
    hl_data <= hl;
    port_in_data <= pin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(execute(op, b2, b3, hl, pin));
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [7:0] op);
    send_word(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain_results();
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_opcode();
    logic [7:0] op;
    if ($urandom_range(0, 99) < 6) return BAD_OPS[$urandom_range(0, 5)];
    do op = 8'($urandom); while (op == OP_HLT0 || op == OP_HLT1 || op == OP_HLT2);
    return op;
  endfunction

  task automatic test_directed();
    send_word(8'h06, 8'hFF, 8'h00, 8'h00, 8'h00); // MVI A,FF
    send_word(8'h04, 8'h01, 8'hFF, 8'hFF, 8'hFF); // ADI: wraps to zero with carry
    send_word(8'h0C, 8'hFF, 8'h00, 8'h00, 8'h00); // ACI uses carry
    send_word(8'h14, 8'h02, 8'h00, 8'h00, 8'h00); // SUI borrows
    send_word(8'h1C, 8'h00, 8'h00, 8'h00, 8'h00); // SBI with borrow in
    send_word(8'h24, 8'hF0, 8'h00, 8'h00, 8'h00); // ANI clears carry
    send_word(8'h2C, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_word(8'h34, 8'h80, 8'h00, 8'h00, 8'h00);
    send_word(8'h3C, 8'hFF, 8'h00, 8'h00, 8'h00); // CPI keeps A
    send_op(8'h09); // DCR B wraps from zero
    send_op(8'h08);
    send_op(8'h02);
    send_op(8'h0A);
    send_op(8'h12);
    send_op(8'h1A);
    send_word(8'h2E, 8'hFF, 8'h00, 8'h00, 8'h00); // MVI H
    send_word(8'h3E, 8'hA5, 8'h00, 8'h00, 8'h00); // MVI M
    send_word(8'hF8, 8'h00, 8'h00, 8'h00, 8'h00); // MOV M,A
    send_word(8'h87, 8'h00, 8'h00, 8'hFF, 8'h00); // ADD M
    send_word(8'h41, 8'h00, 8'h00, 8'h00, 8'hC3); // IN 0
    send_op(8'h7F);                                // OUT 31
    for (int i = 0; i < 6; i++) send_op(BAD_OPS[i]);
    send_word(8'h46, 8'hFF, 8'hFF, 8'h00, 8'h00); // CALL to top of memory
    send_op(8'h07);                                // RET
    send_op(8'h3D);                                // RST 7
    send_word(8'h44, 8'h00, 8'h00, 8'h00, 8'h00); // JMP 0
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_op(random_opcode());
  endtask

  task automatic test_quiet_pause();
    // hold off until the unit has answered everything
    in_valid <= 1'b0;
    drain_results();
    repeat (3) @(posedge clk);
  endtask

  task automatic test_halt();
    logic [7:0] halts [3];
    halts = '{OP_HLT0, OP_HLT1, OP_HLT2};
    send_idle_pct = 30;
    recv_stall_pct = 30;
    send_op(halts[$urandom_range(0, 2)]);
    for (int i = 0; i < 8; i++) send_op(random_opcode());
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    exec_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("next_pc", e.next_pc, next_pc);
        check_field("mem_write", e.mem_write, mem_write);
        check_field("mem_addr", e.mem_addr, mem_addr);
        check_field("write_data", e.write_data, write_data);
        check_field("port_write", e.port_write, port_write);
        check_field("port_number", e.port_number, port_number);
        check_field("acc", e.acc, acc);
        check_field("flags", e.flags, flags);
        check_field("halted", e.halted, halted);
        check_field("invalid_opcode", e.invalid_opcode, invalid_opcode);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 7; i++) gpr[i] = '0;
    for (int i = 0; i < STACK_DEPTH_DEF; i++) ret_stack[i] = '0;
    cpu_flags = '0;
    stk_ptr = '0;
    halt_seen = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 120);
    test_random_phase(85, 0, 120);
    test_quiet_pause();
    test_random_phase(0, 85, 120);
    test_random_phase(32, 32, 120);
    test_random_phase(0, 0, 30);
    test_halt();
    in_valid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
